// ===== rtl/core/gdd_pkg.sv =====
// Shared types, constants and the month table for the Gregorian day-difference block.
`timescale 1ns / 1ps

package gdd_pkg;

	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;
	localparam int COUNT_W = 23;

	// Years before the given year, shifted by 400 so the count never goes negative.
	localparam int ELAPSED_W    = 15;
	localparam int YEAR_OFFSET  = 399;

	// Reciprocal of 100: x / 100 == (x * 5243) >> 19 for every x below 43690.
	localparam int RECIP_100    = 5243;
	localparam int RECIP_W      = 13;
	localparam int RECIP_SHIFT  = 19;
	localparam int PROD_W       = ELAPSED_W + RECIP_W;
	localparam int QUOT_W       = PROD_W - RECIP_SHIFT;

	localparam int MONTH_PART_W = 9;
	localparam int DIFF_W       = COUNT_W + 1;

	localparam int DAYS_PER_YEAR = 365;
	localparam int CENTURY       = 100;

	localparam int COUNT_MAX = (1 << (COUNT_W - 1)) - 1;
	localparam int COUNT_MIN = -(1 << (COUNT_W - 1));

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;

	typedef struct packed {
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
	} date_t;

	// Days in the months of a common year that come before the given month.
	function automatic logic [MONTH_PART_W-1:0] days_before_month(
		input logic [MONTH_W-1:0] mon);
		logic [MONTH_PART_W-1:0] d;
		case (mon)
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

// ===== rtl/core/gdd_day_number.sv =====
// Three-stage pipeline that turns one calendar date into a linear day number.
`timescale 1ns / 1ps

module gdd_day_number (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  gdd_pkg::date_t                date,
	output logic                          out_valid,
	output logic [gdd_pkg::COUNT_W-1:0]   day_num
);

	localparam int EW = gdd_pkg::ELAPSED_W;
	localparam int QW = gdd_pkg::QUOT_W;
	localparam int PW = gdd_pkg::PROD_W;
	localparam int CW = gdd_pkg::COUNT_W;
	localparam int MW = gdd_pkg::MONTH_PART_W;
	localparam int YW = gdd_pkg::YEAR_W;

	logic [gdd_pkg::MONTH_W-1:0] mon_fix;
	logic [EW-1:0]               elapsed;
	logic [PW-1:0]               prod_e;
	logic [PW-1:0]               prod_y;

	logic                          valid_s1;
	logic [gdd_pkg::DAY_W-1:0]     day_s1;
	logic [gdd_pkg::MONTH_W-1:0]   mon_s1;
	logic [YW-1:0]                 year_s1;
	logic [EW-1:0]                 elapsed_s1;
	logic [QW-1:0]                 q_e_s1;
	logic [QW-1:0]                 q_y_s1;

	logic          century;
	logic          leap;
	logic [CW-1:0] year_part;
	logic [MW-1:0] month_part;

	logic          valid_s2;
	logic [CW-1:0] year_part_s2;
	logic [MW-1:0] month_part_s2;

	logic          valid_s3;
	logic [CW-1:0] day_num_s3;

	// Stage 1: clean up the month and divide both year counts by 100.
	always_comb begin
		mon_fix = (date.month inside {[gdd_pkg::MONTH_JAN:4'd12]}) ? date.month
			: gdd_pkg::MONTH_JAN;
		elapsed = EW'(date.year) + EW'(gdd_pkg::YEAR_OFFSET);
		prod_e  = PW'(elapsed) * PW'(gdd_pkg::RECIP_100);
		prod_y  = PW'(date.year) * PW'(gdd_pkg::RECIP_100);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		day_s1     <= date.day;
		mon_s1     <= mon_fix;
		year_s1    <= date.year;
		elapsed_s1 <= elapsed;
		q_e_s1     <= prod_e[PW-1:gdd_pkg::RECIP_SHIFT];
		q_y_s1     <= prod_y[PW-1:gdd_pkg::RECIP_SHIFT];
	end

	// Stage 2: days of the elapsed years, and days into the current year.
	always_comb begin
		century = ({2'b00, year_s1} == 16'(16'(q_y_s1) * 16'(gdd_pkg::CENTURY)));
		leap    = (year_s1[1:0] == 2'b00) && (!century || (q_y_s1[1:0] == 2'b00));
		year_part = CW'(CW'(elapsed_s1) * CW'(gdd_pkg::DAYS_PER_YEAR))
			+ CW'(elapsed_s1 >> 2) - CW'(q_e_s1) + CW'(q_e_s1 >> 2);
		month_part = gdd_pkg::days_before_month(mon_s1) + MW'(day_s1)
			+ MW'(leap && (mon_s1 > gdd_pkg::MONTH_FEB));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		year_part_s2  <= year_part;
		month_part_s2 <= month_part;
	end

	// Stage 3: the day number itself.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		day_num_s3 <= year_part_s2 + CW'(month_part_s2);
	end

	assign out_valid = valid_s3;
	assign day_num   = day_num_s3;

endmodule

// ===== rtl/core/gregorian_day_difference.sv =====
// Top level: signed day count between two Gregorian dates.
// An accepted word passes through both day-number pipelines and then the output register before done rises.
// Throughput: one word per cycle; busy is always low, so start may stay high every cycle.
// The depth is set by the three stages of each day-number pipeline plus the subtract stage.
// Reset (arst_n low, asynchronous) clears every valid bit, so no stale word emerges.
`timescale 1ns / 1ps

module gregorian_day_difference (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [gdd_pkg::DAY_W-1:0]          end_day,
	input  logic [gdd_pkg::MONTH_W-1:0]        end_month,
	input  logic [gdd_pkg::YEAR_W-1:0]         end_year,
	input  logic [gdd_pkg::DAY_W-1:0]          start_day,
	input  logic [gdd_pkg::MONTH_W-1:0]        start_month,
	input  logic [gdd_pkg::YEAR_W-1:0]         start_year,
	output logic                               done,
	output logic signed [gdd_pkg::COUNT_W-1:0] day_count
);

	localparam int CW = gdd_pkg::COUNT_W;
	localparam int DW = gdd_pkg::DIFF_W;

	gdd_pkg::date_t end_date;
	gdd_pkg::date_t start_date;
	logic           accept;
	logic           end_valid;
	logic           start_valid;
	logic [CW-1:0]  end_num;
	logic [CW-1:0]  start_num;
	logic signed [DW-1:0] diff;
	logic signed [CW-1:0] clipped;

	logic                 valid_s4;
	logic signed [CW-1:0] count_s4;

	// Every stage moves every cycle and the receiver cannot stall, so the
	// block never has a reason to refuse a word.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign end_date   = '{day: end_day, month: end_month, year: end_year};
	assign start_date = '{day: start_day, month: start_month, year: start_year};

	// Both dates run through identical pipelines side by side, so their day
	// numbers arrive in the same cycle.
	gdd_day_number u_end_num (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.date      (end_date),
		.out_valid (end_valid),
		.day_num   (end_num)
	);

	gdd_day_number u_start_num (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.date      (start_date),
		.out_valid (start_valid),
		.day_num   (start_num)
	);

	// The constant offset inside each day number cancels in the subtraction.
	// Valid dates always fit the result; years beyond 9999 can overflow it,
	// and the count then clips to the most negative or most positive value.
	always_comb begin
		diff = signed'(DW'(end_num)) - signed'(DW'(start_num));
		if (diff > DW'(gdd_pkg::COUNT_MAX)) begin
			clipped = CW'(gdd_pkg::COUNT_MAX);
		end else if (diff < DW'(gdd_pkg::COUNT_MIN)) begin
			clipped = CW'(gdd_pkg::COUNT_MIN);
		end else begin
			clipped = diff[CW-1:0];
		end
	end

	// Output register: done is a one-cycle strobe per word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= end_valid && start_valid;
		end
	end

	always_ff @(posedge clk) begin
		count_s4 <= clipped;
	end

	assign done      = valid_s4;
	assign day_count = count_s4;

	// A word that is accepted always comes out as done once it has passed both pipelines and the output register.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##3 done)
		else $error("accepted word did not produce done after four cycles");

	// No result appears without a matching accepted word.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> ##3 !done)
		else $error("done raised without a matching accepted word");

	// Identical dates give a count of zero.
	a_same_date: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(accept, 4)
		&& ($past(end_day, 4) == $past(start_day, 4))
		&& ($past(end_month, 4) == $past(start_month, 4))
		&& ($past(end_year, 4) == $past(start_year, 4))
		|-> (day_count == '0))
		else $error("equal dates gave a nonzero day count");

endmodule
